>>> rtl/rsenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsenc_pkg;

  typedef logic [7:0] gf_sym_t;

  localparam logic REG_FIELD_POLY = 1'b0;
  localparam logic REG_FIRST_ROOT = 1'b1;

  // Multiplication by alpha = 2 with reduction by the low byte of the field polynomial.
  function automatic gf_sym_t gf_xtime(input gf_sym_t a, input gf_sym_t red);
    gf_xtime = a[7] ? ({a[6:0], 1'b0} ^ red) : {a[6:0], 1'b0};
  endfunction

  function automatic gf_sym_t gf_mul(input gf_sym_t a, input gf_sym_t b, input gf_sym_t red);
    gf_sym_t acc;
    gf_sym_t sh;
    acc = '0;
    sh  = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ sh;
      end
      sh = gf_xtime(sh, red);
    end
    gf_mul = acc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/reed_solomon_parity_encoder_t2.sv
`timescale 1ns / 1ps
`default_nettype none
// A last item's parity goes to the output register, or to a skid register while that is held.
// Throughput: one item per cycle while the skid register is empty and the sequencer is idle.
// After reset and after each configuration write a sequencer rederives the generator,
// one doubling or one root product per cycle, and no item is accepted meanwhile.
// Reset is synchronous and clears the parity state.
module reed_solomon_parity_encoder_t2
  import rsenc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // parity_0, parity_1, parity_2, parity_3
);

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_POW = 2'd1;
  localparam logic [1:0] ST_GEN = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [1:0]  step_r, step_nxt;
  gf_sym_t     root_r, root_nxt;
  gf_sym_t     red_r, red_nxt;
  logic [7:0]  first_root_r, first_root_nxt;
  gf_sym_t     g0_r, g0_nxt, g1_r, g1_nxt, g2_r, g2_nxt, g3_r, g3_nxt;

  gf_sym_t     p0_r, p1_r, p2_r, p3_r;
  gf_sym_t     p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  gf_sym_t     fb, np0, np1, np2;
  gf_sym_t     rn;

  logic [31:0] out_r, out_nxt, skid_r, skid_nxt;
  logic        out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic        in_fire, res, taken;

  assign in_tready  = (state_r == ST_RUN) && !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign res        = in_fire && in_tlast;
  assign taken      = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign fb  = p0_r ^ in_tdata;
  assign np0 = p1_r ^ gf_mul(fb, g1_r, red_r);
  assign np1 = p2_r ^ gf_mul(fb, g2_r, red_r);
  assign np2 = p3_r ^ gf_mul(fb, g3_r, red_r);

  always_comb begin
    p0_nxt = p0_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    p3_nxt = p3_r;
    if (in_fire) begin
      if (in_tlast) begin
        p0_nxt = '0;
        p1_nxt = '0;
        p2_nxt = '0;
        p3_nxt = '0;
      end else begin
        p0_nxt = np0;
        p1_nxt = np1;
        p2_nxt = np2;
        p3_nxt = fb;
      end
    end
  end

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || taken) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (res) begin
        out_nxt       = {fb, np2, np1, np0};
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res) begin
      skid_nxt       = {fb, np2, np1, np0};
      skid_valid_nxt = 1'b1;
    end
  end

  assign rn = gf_xtime(root_r, red_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    root_nxt       = root_r;
    red_nxt        = red_r;
    first_root_nxt = first_root_r;
    g0_nxt         = g0_r;
    g1_nxt         = g1_r;
    g2_nxt         = g2_r;
    g3_nxt         = g3_r;
    case (state_r)
      ST_POW: begin
        if (cnt_r == '0) begin
          g0_nxt    = root_r;
          g1_nxt    = 8'd1;
          g2_nxt    = '0;
          g3_nxt    = '0;
          step_nxt  = '0;
          state_nxt = ST_GEN;
        end else begin
          root_nxt = rn;
          cnt_nxt  = cnt_r - 8'd1;
        end
      end
      ST_GEN: begin
        // Multiply the partial generator by (x + alpha^(b0+step+1)).
        root_nxt = rn;
        g0_nxt   = gf_mul(g0_r, rn, red_r);
        g1_nxt   = g0_r ^ gf_mul(g1_r, rn, red_r);
        if (step_r == 2'd0) begin
          g2_nxt = 8'd1;
        end else begin
          g2_nxt = g1_r ^ gf_mul(g2_r, rn, red_r);
        end
        if (step_r == 2'd1) begin
          g3_nxt = 8'd1;
        end else if (step_r == 2'd2) begin
          g3_nxt = g2_r ^ gf_mul(g3_r, rn, red_r);
        end
        if (step_r == 2'd2) begin
          state_nxt = ST_RUN;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      if (cfg_addr == REG_FIELD_POLY) begin
        red_nxt = cfg_wdata[7:0];
        cnt_nxt = first_root_r;
      end else begin
        first_root_nxt = cfg_wdata[7:0];
        cnt_nxt        = cfg_wdata[7:0];
      end
      root_nxt  = 8'd1;
      state_nxt = ST_POW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_POW;
      cnt_r        <= '0;
      step_r       <= '0;
      root_r       <= 8'd1;
      red_r        <= 8'h1D;
      first_root_r <= '0;
      p0_r         <= '0;
      p1_r         <= '0;
      p2_r         <= '0;
      p3_r         <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      step_r       <= step_nxt;
      root_r       <= root_nxt;
      red_r        <= red_nxt;
      first_root_r <= first_root_nxt;
      p0_r         <= p0_nxt;
      p1_r         <= p1_nxt;
      p2_r         <= p2_nxt;
      p3_r         <= p3_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g0_r   <= g0_nxt;
    g1_r   <= g1_nxt;
    g2_r   <= g2_nxt;
    g3_r   <= g3_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rsenc_pkg::*;

  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_DIRECTED = 20;
  localparam int PRESSURE_PHASE = 4;

  localparam int POLY_SET [PHASES] = '{285, 285, 511, 256, 29, 285, 391, 0, 0, 285};
  localparam int ROOT_SET [PHASES] = '{0, 255, 254, 1, 0, 120, 3, 0, 0, 0};
  localparam int SEND_IDLE [4] = '{0, 53, 0, 30};
  localparam int RECV_STALL [4] = '{0, 0, 53, 30};

  typedef struct packed {
    gf_sym_t p3;
    gf_sym_t p2;
    gf_sym_t p1;
    gf_sym_t p0;
  } parity_word_t;

  typedef struct packed {
    gf_sym_t      sym;
    logic         last;
    logic         known;
    parity_word_t parity;
  } directed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = REG_FIELD_POLY;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;   // data_byte[7:0]
  logic        in_tlast = 1'b0; // last
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;       // parity_0, parity_1, parity_2, parity_3

  reed_solomon_parity_encoder_t2 uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Parity words of the codewords accepted but not yet checked, oldest first.
  parity_word_t parity_pending [$];

  logic [8:0] poly_setting = 9'd285;
  logic [7:0] root_setting = 8'd0;
  gf_sym_t    gen_coef [3];
  gf_sym_t    parity_state [4] = '{default: 8'h00};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_req = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int words_checked = 0;
  int symbols_sent = 0;
  int config_writes = 0;

  directed_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{8'h01, 1'b1, 1'b1, 32'h010F_3678},
    '{8'h02, 1'b1, 1'b1, 32'h021E_6CF0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hAA, 1'b0, 1'b0, 32'h0},
    '{8'h55, 1'b0, 1'b0, 32'h0},
    '{8'h01, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{8'h12, 1'b0, 1'b0, 32'h0},
    '{8'h34, 1'b0, 1'b0, 32'h0},
    '{8'h56, 1'b0, 1'b0, 32'h0},
    '{8'h78, 1'b0, 1'b0, 32'h0},
    '{8'h9A, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic gf_sym_t gf_double(gf_sym_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? poly_setting[7:0] : 8'h00);
  endfunction

  function automatic gf_sym_t gf_times(gf_sym_t a, gf_sym_t b);
    gf_sym_t acc;
    acc = 8'h00;
    for (int k = 7; k >= 0; k--) begin
      acc = gf_double(acc) ^ (b[k] ? a : 8'h00);
    end
    return acc;
  endfunction

  // Expands the product of (x + alpha^(b0+i)) for i = 0..3 and keeps g1..g3.
  function automatic void rederive_generator();
    gf_sym_t root;
    gf_sym_t g [5];
    root = 8'h01;
    for (int k = 0; k < int'(root_setting); k++) begin
      root = gf_double(root);
    end
    g = '{root, 8'h01, 8'h00, 8'h00, 8'h00};
    for (int i = 2; i <= 4; i++) begin
      root = gf_double(root);
      g[i] = 8'h01;
      for (int j = i - 1; j > 0; j--) begin
        g[j] = g[j - 1] ^ gf_times(g[j], root);
      end
      g[0] = gf_times(g[0], root);
    end
    gen_coef[0] = g[1];
    gen_coef[1] = g[2];
    gen_coef[2] = g[3];
  endfunction

  function automatic void advance_parity(gf_sym_t sym, logic last, logic known,
                                         parity_word_t typed);
    gf_sym_t fb;
    fb = parity_state[0] ^ sym;
    parity_state[0] = parity_state[1] ^ gf_times(fb, gen_coef[0]);
    parity_state[1] = parity_state[2] ^ gf_times(fb, gen_coef[1]);
    parity_state[2] = parity_state[3] ^ gf_times(fb, gen_coef[2]);
    parity_state[3] = fb;
    if (last) begin
      if (known) begin
        parity_pending.push_back(typed);
      end else begin
        parity_pending.push_back({parity_state[3], parity_state[2],
                                  parity_state[1], parity_state[0]});
      end
      parity_state = '{default: 8'h00};
    end
  endfunction

  task automatic send_symbol(input gf_sym_t sym, input logic last, input logic known,
                             input parity_word_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= sym;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    advance_parity(sym, last, known, typed);
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (parity_pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic addr, input logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_FIELD_POLY) begin
      poly_setting = value;
    end else begin
      root_setting = value[7:0];
    end
    rederive_generator();
    config_writes++;
    repeat (2) @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  task automatic check_parity(input logic [31:0] got);
    logic [31:0] want;
    if (parity_pending.size() == 0) begin
      errors++;
      $display("%0t: expected no parity word, got %h", $time, got);
    end else begin
      want = parity_pending.pop_front();
      words_checked++;
      for (int f = 0; f < 4; f++) begin
        if (got[8*f +: 8] !== want[8*f +: 8]) begin
          errors++;
          $display("%0t: parity_%0d expected %h got %h", $time, f,
                   want[8*f +: 8], got[8*f +: 8]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_parity(out_tdata);
    end
  end

  // The long hold-off lets the encoder back up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** reed_solomon_parity_encoder_t2: FAILED **");
    $finish;
  end

  initial begin
    int sent;
    int cw_len;
    int mode;
    logic [8:0] poly;
    logic [8:0] root;
    rederive_generator();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      send_symbol(directed_rows[r].sym, directed_rows[r].last, directed_rows[r].known,
                  directed_rows[r].parity);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 7 || p == 8) begin
        poly = 9'($urandom_range(511, 256));
        root = 9'($urandom_range(254));
      end else begin
        poly = 9'(POLY_SET[p]);
        root = 9'(ROOT_SET[p]);
      end
      write_register(REG_FIELD_POLY, poly);
      write_register(REG_FIRST_ROOT, root);
      mode = p % 4;
      send_idle_pct = SEND_IDLE[mode];
      recv_stall_pct = RECV_STALL[mode];
      if (p == PRESSURE_PHASE) begin
        pressure_req = 1'b1;
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        cw_len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
        for (int i = 0; i < cw_len; i++) begin
          send_symbol(gf_sym_t'($urandom_range(255)), i == cw_len - 1, 1'b0, '0);
        end
        sent += cw_len;
      end
      drain();
    end

    $display("Encoded %0d symbols into %0d checked parity words over %0d register writes,",
             symbols_sent, words_checked, config_writes);
    $display("with odd field polynomials, first roots 0 to 255, idling and a long hold-off.");
    if (errors == 0 && parity_pending.size() == 0) begin
      $display("** reed_solomon_parity_encoder_t2: PASSED **");
    end else begin
      $display("** reed_solomon_parity_encoder_t2: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rsenc_pkg.sv
rtl/reed_solomon_parity_encoder_t2.sv
dv/testbench.sv
